/* design/cfpr_pkg.sv */
// ----------------------------------------------------------------------------
// cfpr_pkg
// Shared constants and types for the CR/LF framed pose receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

    // Frame geometry
    localparam int PAYLOAD_BYTES = 24;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    // Payload word positions that leave the block
    localparam int HEADING_WORD = 0;
    localparam int POS_X_WORD   = 3;
    localparam int POS_Y_WORD   = 4;

    // Delimiter bytes
    localparam logic [7:0] HDR_FIRST  = 8'h0D;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TRL_FIRST  = 8'h0A;
    localparam logic [7:0] TRL_SECOND = 8'h0D;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_DATA = 3'd2,
        PH_TRL1 = 3'd3,
        PH_TRL2 = 3'd4
    } phase_t;

    typedef struct packed {
        logic [31:0] heading_bits;
        logic [31:0] pos_x_bits;
        logic [31:0] pos_y_bits;
    } pose_t;

endpackage

`default_nettype wire

/* design/crlf_framed_pose_receiver.sv */
// ----------------------------------------------------------------------------
// crlf_framed_pose_receiver
// Parses CR LF <payload> LF CR frames from a byte stream and emits a pose.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                   Beat
//  s_        in         s_valid s_ready s_rx_byte               one rx byte
//  m_        out        m_valid m_ready m_heading_bits          one pose per
//                       m_pos_x_bits m_pos_y_bits               good frame
//
//  One byte is taken per clock while s_ready is high; the closing CR of
//  the trailer pushes the finished pose into the registered result buffer.
//  Reset (aresetn low, synchronous) returns the parser to header hunt and
//  empties the result buffer; captured payload bytes are not cleared.
//  s_ready drops only when both result slots are full (m_ready held low
//  while two poses queue up); it comes from a register, not from m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_framed_pose_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_heading_bits,
    output logic [31:0]      m_pos_x_bits,
    output logic [31:0]      m_pos_y_bits
);
    import cfpr_pkg::*;

    logic  byte_fire;
    logic  emit;
    logic  space;
    pose_t pose;
    pose_t out_pose;

    // Advance the parser on every byte transfer
    assign s_ready   = space;
    assign byte_fire = s_valid && s_ready;

    cfpr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_rx_byte),
        .pose      (pose),
        .emit      (emit)
    );

    // Hold finished poses until the consumer takes them
    cfpr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (pose),
        .space     (space),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_pose)
    );

    assign m_heading_bits = out_pose.heading_bits;
    assign m_pos_x_bits   = out_pose.pos_x_bits;
    assign m_pos_y_bits   = out_pose.pos_y_bits;

endmodule

`default_nettype wire

/* design/cfpr_parser.sv */
// ----------------------------------------------------------------------------
// cfpr_parser
// Frame phase tracker and payload capture; flags a finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           byte_fire,
    input  wire logic [7:0]     rx_byte,
    output cfpr_pkg::pose_t     pose,
    output logic                emit
);
    import cfpr_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       store_reg [PAYLOAD_BYTES];

    // Next phase and payload index
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (byte_fire) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                end
                PH_HDR2: begin
                    if (rx_byte == HDR_SECOND) begin
                        idx_next   = '0;
                        phase_next = PH_DATA;
                    end else if (rx_byte != HDR_FIRST) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (idx_reg == IDX_W'(PAYLOAD_BYTES - 1)) begin
                        idx_next   = '0;
                        phase_next = PH_TRL1;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                PH_TRL1: begin
                    phase_next = (rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                end
                PH_TRL2: begin
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Result flag and assembled words (little-endian within each word)
    always_comb begin
        emit = byte_fire && (phase_reg == PH_TRL2) && (rx_byte == TRL_SECOND);
        for (int b = 0; b < 4; b++) begin
            pose.heading_bits[8*b +: 8] = store_reg[4*HEADING_WORD + b];
            pose.pos_x_bits[8*b +: 8]   = store_reg[4*POS_X_WORD + b];
            pose.pos_y_bits[8*b +: 8]   = store_reg[4*POS_Y_WORD + b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (byte_fire && (phase_reg == PH_DATA)) begin
            store_reg[idx_reg] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

/* design/cfpr_out_buf.sv */
// ----------------------------------------------------------------------------
// cfpr_out_buf
// Two-entry result buffer (main plus skid) with a registered ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cfpr_pkg::pose_t  push_data,
    output logic                  space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cfpr_pkg::pose_t       out_data
);
    import cfpr_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    pose_t main_reg, main_next;
    pose_t skid_reg, skid_next;
    logic  pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (main_valid_reg) begin
            if (pop && push) begin
                main_next = push_data;
            end else if (pop) begin
                main_valid_next = 1'b0;
            end else if (push) begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else begin
            if (push) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

/* dv/crlf_framed_pose_receiver_tb.sv */
// ----------------------------------------------------------------------------
// crlf_framed_pose_receiver_tb
// Self-checking bench for the CR/LF framed pose receiver: drives byte streams
// made of clean, repeated-CR, corrupted and truncated frames plus line noise,
// tracks the frame parser in a local shadow, and compares every pose.
// ----------------------------------------------------------------------------

module crlf_framed_pose_receiver_tb;
    import cfpr_pkg::*;

    localparam int STALL_MAX      = 11;    // longest idle draw on either side
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer at all
    localparam int RANDOM_BYTES   = 890;   // bytes in the randomized stream
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last pose

    typedef enum int {
        PL_RANDOM,
        PL_ZEROS,
        PL_ONES,
        PL_DELIMS
    } payload_style_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_heading_bits;
    logic [31:0] m_pos_x_bits;
    logic [31:0] m_pos_y_bits;

    crlf_framed_pose_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_heading_bits (m_heading_bits),
        .m_pos_x_bits   (m_pos_x_bits),
        .m_pos_y_bits   (m_pos_y_bits)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the parser: phase, payload position and captured bytes.
    phase_t      rx_phase = PH_HUNT;
    int          rx_index = 0;
    logic [7:0]  rx_store [PAYLOAD_BYTES];

    // Poses the shadow has produced and the output has not yet delivered.
    pose_t       pending_poses [$];

    // Payload of the next frame to be sent.
    logic [7:0]  frame_payload [PAYLOAD_BYTES];

    bit          sender_idles = 1'b1;
    bit          sink_idles   = 1'b1;
    int          error_count  = 0;
    int          bytes_sent   = 0;
    int          frames_sent  = 0;
    int          poses_checked = 0;
    int          idle_cycles  = 0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Payload word k, little-endian: byte 4k is least significant.
    function automatic logic [31:0] payload_word(input int k);
        return {rx_store[4*k+3], rx_store[4*k+2], rx_store[4*k+1], rx_store[4*k]};
    endfunction

    // Advance the shadow parser by one transferred byte; queue a pose when the
    // closing CR of the trailer completes a frame.
    function automatic void track_rx_byte(input logic [7:0] b);
        pose_t pose;
        case (rx_phase)
            PH_HUNT: begin
                rx_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
            PH_HDR2: begin
                // A repeated CR holds the phase; LF opens the payload.
                if (b == HDR_SECOND) begin
                    rx_index = 0;
                    rx_phase = PH_DATA;
                end else if (b != HDR_FIRST) begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                // Every byte is payload here, delimiters included.
                rx_store[rx_index] = b;
                rx_index++;
                if (rx_index >= PAYLOAD_BYTES) begin
                    rx_index = 0;
                    rx_phase = PH_TRL1;
                end
            end
            PH_TRL1: begin
                rx_phase = (b == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2: begin
                // Any byte ends the frame; only CR yields a pose.
                if (b == TRL_SECOND) begin
                    pose.heading_bits = payload_word(HEADING_WORD);
                    pose.pos_x_bits   = payload_word(POS_X_WORD);
                    pose.pos_y_bits   = payload_word(POS_Y_WORD);
                    pending_poses.push_back(pose);
                end
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Offer one byte after a random idle gap, hold it until transferred,
    // then let the shadow consume it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0)
            sender_idles = !sender_idles;
        gap = sender_idles ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    function automatic void fill_payload(input payload_style_t style);
        foreach (frame_payload[i]) begin
            case (style)
                PL_ZEROS: frame_payload[i] = 8'h00;
                PL_ONES:  frame_payload[i] = 8'hFF;
                PL_DELIMS: begin
                    case ($urandom_range(0, 2))
                        0:       frame_payload[i] = HDR_FIRST;
                        1:       frame_payload[i] = HDR_SECOND;
                        default: frame_payload[i] = 8'($urandom);
                    endcase
                end
                default:  frame_payload[i] = 8'($urandom);
            endcase
        end
    endfunction

    // Send one frame around frame_payload. Optionally pad the header with
    // extra CRs, flip bits in one delimiter byte, or stop after keep bytes
    // (keep < 0 sends the whole frame).
    task automatic send_frame(input int extra_cr, input bit corrupt, input int keep);
        logic [7:0] seq [$];
        int         pos;
        int         last;
        seq.push_back(HDR_FIRST);
        repeat (extra_cr) seq.push_back(HDR_FIRST);
        seq.push_back(HDR_SECOND);
        foreach (frame_payload[i]) seq.push_back(frame_payload[i]);
        seq.push_back(TRL_FIRST);
        seq.push_back(TRL_SECOND);
        last = seq.size() - 1;
        if (corrupt) begin
            // Pick a header byte or one of the two trailer bytes.
            pos = $urandom_range(0, extra_cr + 3);
            if (pos > extra_cr + 1)
                pos = last - (extra_cr + 3 - pos);
            seq[pos] = seq[pos] ^ 8'($urandom_range(1, 255));
        end
        if (keep < 0 || keep > seq.size())
            keep = seq.size();
        frames_sent++;
        for (int i = 0; i < keep; i++)
            send_byte(seq[i]);
    endtask

    // Payload extremes, a payload of alternating CR and LF bytes, and a ramp.
    task automatic test_payload_extremes;
        fill_payload(PL_ZEROS);
        send_frame(0, 1'b0, -1);
        fill_payload(PL_ONES);
        send_frame(0, 1'b0, -1);
        foreach (frame_payload[i])
            frame_payload[i] = i[0] ? HDR_SECOND : HDR_FIRST;
        send_frame(0, 1'b0, -1);
        foreach (frame_payload[i])
            frame_payload[i] = 8'(i * 8'h0B + 8'h5A);
        send_frame(0, 1'b0, -1);
    endtask

    // Several CRs before the LF must keep waiting for the LF.
    task automatic test_repeated_header_start;
        fill_payload(PL_RANDOM);
        send_frame(3, 1'b0, -1);
    endtask

    // Wrong bytes while hunting and while waiting for the header LF.
    task automatic test_wrong_bytes;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h55);
        send_byte(HDR_FIRST);
        send_byte(8'hFF);
        fill_payload(PL_RANDOM);
        send_frame(0, 1'b0, -1);
    endtask

    // Bad trailer bytes: CR where LF belongs, then LF where the closing CR
    // belongs; neither may produce a pose.
    task automatic test_trailer_end;
        fill_payload(PL_RANDOM);
        send_frame(0, 1'b0, PAYLOAD_BYTES + 2);
        send_byte(HDR_FIRST);
        send_byte(8'h33);
        fill_payload(PL_RANDOM);
        send_frame(0, 1'b0, PAYLOAD_BYTES + 3);
        send_byte(TRL_FIRST);
        fill_payload(PL_RANDOM);
        send_frame(0, 1'b0, -1);
    endtask

    // Mostly clean frames with random content; the rest are corrupted or
    // truncated frames and bursts of line noise.
    task automatic test_random_traffic;
        int stop_at;
        int roll;
        int extra;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                fill_payload(PL_RANDOM);
            else if (roll < 80)
                fill_payload(PL_ZEROS);
            else if (roll < 90)
                fill_payload(PL_ONES);
            else
                fill_payload(PL_DELIMS);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            roll  = $urandom_range(0, 99);
            if (roll < 70)
                send_frame(extra, 1'b0, -1);
            else if (roll < 82)
                send_frame(extra, 1'b1, -1);
            else if (roll < 90)
                send_frame(extra, 1'b0, $urandom_range(1, PAYLOAD_BYTES + extra + 3));
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    // Result side: stall m_ready at random, then compare each pose transfer
    // with the oldest pending pose.
    initial begin
        int    stall;
        pose_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                sink_idles = !sink_idles;
            stall = sink_idles ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                // Hold off until a pose is offered, so the stall lands on it.
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall - 1) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_poses.size() == 0) begin
                report_error($sformatf("pose with none pending: %h %h %h",
                             m_heading_bits, m_pos_x_bits, m_pos_y_bits));
            end else begin
                want = pending_poses.pop_front();
                poses_checked++;
                if (m_heading_bits !== want.heading_bits)
                    report_error($sformatf("heading_bits got %h want %h",
                                 m_heading_bits, want.heading_bits));
                if (m_pos_x_bits !== want.pos_x_bits)
                    report_error($sformatf("pos_x_bits got %h want %h",
                                 m_pos_x_bits, want.pos_x_bits));
                if (m_pos_y_bits !== want.pos_y_bits)
                    report_error($sformatf("pos_y_bits got %h want %h",
                                 m_pos_y_bits, want.pos_y_bits));
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_payload_extremes;
        test_repeated_header_start;
        test_wrong_bytes;
        test_trailer_end;
        test_random_traffic;
        s_valid <= 1'b0;

        // Drain: wait for every pending pose, then let the output settle.
        while (pending_poses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d received bytes in %0d frame attempts plus noise",
                 bytes_sent, frames_sent);
        $display("Compared %0d poses field by field, %0d mismatches",
                 poses_checked, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
